/* rtl/i2c_master_transfer_sequencer_assert.svh */
// Assertion macros for the I2C master transfer sequencer RTL.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising clock edge outside reset.
`define I2CMS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("i2cms: implication check failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define I2CMS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("i2cms: next-cycle check failed");

`else

`define I2CMS_ASSERT_IMPL(label, clk, rst, ante, cons)
`define I2CMS_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/i2cms_pkg.sv */
// Package with the types and status codes of the I2C master transfer sequencer.
package i2cms_pkg;

   // Command codes of a request beat.
   typedef enum logic [1:0] {
      CMD_START_WRITE = 2'd0,
      CMD_START_READ  = 2'd1,
      CMD_EVENT       = 2'd2,
      CMD_STOP        = 2'd3
   } cmd_type;

   // Bus actions requested in a response beat.
   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_START   = 3'd1,
      ACT_ADDR    = 3'd2,
      ACT_DATA    = 3'd3,
      ACT_RACK    = 3'd4,
      ACT_RNACK   = 3'd5,
      ACT_STOP    = 3'd6,
      ACT_RELEASE = 3'd7
   } action_type;

   // Transfer phases; code seven is unreachable and treated as idle.
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_STAW  = 3'd1,
      PH_ADDRW = 3'd2,
      PH_WDATA = 3'd3,
      PH_STAR  = 3'd4,
      PH_ADDRR = 3'd5,
      PH_RDATA = 3'd6
   } phase_type;

   // Bus status codes after masking the low three bits.
   localparam logic [7:0] ST_MASK       = 8'hF8;
   localparam logic [7:0] ST_START      = 8'h08;
   localparam logic [7:0] ST_RESTART    = 8'h10;
   localparam logic [7:0] ST_ADDRW_ACK  = 8'h18;
   localparam logic [7:0] ST_WDATA_ACK  = 8'h28;
   localparam logic [7:0] ST_WDATA_NACK = 8'h30;
   localparam logic [7:0] ST_ADDRR_ACK  = 8'h40;
   localparam logic [7:0] ST_RDATA_ACK  = 8'h50;
   localparam logic [7:0] ST_RDATA_NACK = 8'h58;

   // One request beat.
   typedef struct packed {
      cmd_type    command;
      logic [6:0] device_address;
      logic [7:0] transfer_length;
      logic [7:0] status_code;
      logic [7:0] received_byte;
      logic [7:0] next_tx_byte;
   } req_type;

   // Transfer state carried from beat to beat.
   typedef struct packed {
      phase_type  phase;
      logic [7:0] address_byte;
      logic [7:0] remaining;
      logic [7:0] done_count;
   } state_type;

   // One response beat.
   typedef struct packed {
      action_type action;
      logic [7:0] out_byte;
      logic       store_valid;
      logic [7:0] stored_byte;
      logic [7:0] byte_count;
      phase_type  phase;
      logic       accepted;
   } result_type;

endpackage

/* rtl/i2c_master_transfer_sequencer.sv */
// I2C master transfer sequencer: turns commands and bus status beats into bus actions.
//
// Request channel (req_*): each beat is a start-write, start-read, bus status event or
// stop command with its address, length, status and data fields. A beat is taken on a
// rising edge with req_valid high and req_stall low.
// Response channel (rsp_*): exactly one beat per request beat, in order, carrying the
// bus action, the byte to send, any received byte, the byte count, the phase after the
// beat and whether a start was taken.
// Path: a request beat is taken into the input register, decoded against the transfer
// state and written to the response register, whose beat shows on rsp_valid.
// Throughput: one beat per cycle while the receiver does not stall; the limit is the state
// update between the input register and the response register.
// When the receiver holds rsp_stall, the response register keeps its beat, the input
// register fills, and req_stall rises only while both are occupied.
// Reset (synchronous, active high) empties both registers and returns the transfer
// state to idle with address, remaining count and byte count cleared.
`include "i2c_master_transfer_sequencer_assert.svh"

module i2c_master_transfer_sequencer
   import i2cms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_command,
   input  logic [6:0] req_device_address,
   input  logic [7:0] req_transfer_length,
   input  logic [7:0] req_status_code,
   input  logic [7:0] req_received_byte,
   input  logic [7:0] req_next_tx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_action,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_store_valid,
   output logic [7:0] rsp_stored_byte,
   output logic [7:0] rsp_byte_count,
   output logic [2:0] rsp_phase,
   output logic       rsp_accepted
);

   logic       in_valid_ff, in_valid_in;
   req_type    in_req_ff, in_req_in;
   state_type  state_ff, state_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_rsp_ff, out_rsp_in;

   state_type  step_state;
   result_type step_result;
   logic       out_free;
   logic       advance;
   logic       req_take;

   // Pipeline control: the input register moves on when the response register frees up.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   // Decode of the registered beat.
   i2cms_step u_step (
      .req        (in_req_ff),
      .state      (state_ff),
      .state_next (step_state),
      .result     (step_result)
   );

   // Next values of the input register, state and response register.
   always_comb begin
      in_valid_in = in_valid_ff;
      in_req_in   = in_req_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_req_in   = '{command:         cmd_type'(req_command),
                         device_address:  req_device_address,
                         transfer_length: req_transfer_length,
                         status_code:     req_status_code,
                         received_byte:   req_received_byte,
                         next_tx_byte:    req_next_tx_byte};
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      state_in     = state_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      out_rsp_in   = out_rsp_ff;
      if (advance) begin
         state_in     = step_state;
         out_valid_in = 1'b1;
         out_rsp_in   = step_result;
      end
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '{phase: PH_IDLE, address_byte: 8'd0, remaining: 8'd0,
                           done_count: 8'd0};
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      in_req_ff  <= in_req_in;
      out_rsp_ff <= out_rsp_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_action      = out_rsp_ff.action;
   assign rsp_out_byte    = out_rsp_ff.out_byte;
   assign rsp_store_valid = out_rsp_ff.store_valid;
   assign rsp_stored_byte = out_rsp_ff.stored_byte;
   assign rsp_byte_count  = out_rsp_ff.byte_count;
   assign rsp_phase       = out_rsp_ff.phase;
   assign rsp_accepted    = out_rsp_ff.accepted;

   // A decoded beat always lands in the response register.
   `I2CMS_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, out_valid_ff)
   // Back-pressure only arises with a beat waiting in the input register.
   `I2CMS_ASSERT_IMPL(a_stall_needs_beat, clock, reset, req_stall, in_valid_ff)
   // A taken start always requests a start condition.
   `I2CMS_ASSERT_IMPL(a_accept_is_start, clock, reset, out_valid_ff && out_rsp_ff.accepted,
                      out_rsp_ff.action == ACT_START)
   // A stored byte only comes from the read-data phase or its final release.
   `I2CMS_ASSERT_IMPL(a_store_in_read, clock, reset, out_valid_ff && out_rsp_ff.store_valid,
                      out_rsp_ff.phase == PH_RDATA || out_rsp_ff.phase == PH_IDLE)

endmodule

/* rtl/i2cms_step.sv */
// Next-state and response logic for one request beat of the transfer sequencer.
module i2cms_step
   import i2cms_pkg::*;
(
   input  req_type    req,
   input  state_type  state,
   output state_type  state_next,
   output result_type result
);

   logic [7:0] status;
   logic [7:0] remaining_dec;
   logic [7:0] done_inc;

   assign status        = req.status_code & ST_MASK;
   assign done_inc      = state.done_count + 8'd1;
   // A zero count holds instead of wrapping on reads.
   assign remaining_dec = (state.remaining != 8'd0) ? (state.remaining - 8'd1) : 8'd0;

   // Decode the command against the current phase.
   always_comb begin
      state_next         = state;
      result.action      = ACT_NONE;
      result.out_byte    = 8'd0;
      result.store_valid = 1'b0;
      result.stored_byte = 8'd0;
      result.accepted    = 1'b0;

      case (req.command)
         CMD_START_WRITE, CMD_START_READ: begin
            if (state.phase == PH_IDLE) begin
               state_next.address_byte = {req.device_address,
                                          (req.command == CMD_START_READ)};
               state_next.phase        = (req.command == CMD_START_WRITE) ? PH_STAW : PH_STAR;
               state_next.remaining    = req.transfer_length;
               state_next.done_count   = 8'd0;
               result.action           = ACT_START;
               result.accepted         = 1'b1;
            end
         end
         CMD_STOP: begin
            result.action = ACT_STOP;
         end
         default: begin
            // Bus status event.
            state_next.phase = PH_IDLE;
            result.action    = ACT_RELEASE;
            case (state.phase)
               PH_STAW, PH_STAR: begin
                  if (status == ST_START || status == ST_RESTART) begin
                     state_next.phase = (state.phase == PH_STAW) ? PH_ADDRW : PH_ADDRR;
                     result.out_byte  = state.address_byte;
                     result.action    = ACT_ADDR;
                  end
               end
               PH_ADDRW, PH_WDATA: begin
                  // An address ACK sends the first data byte like a data ACK does.
                  if (((state.phase == PH_ADDRW && status == ST_ADDRW_ACK) ||
                       (state.phase == PH_WDATA && status == ST_WDATA_ACK)) &&
                      state.remaining != 8'd0) begin
                     state_next.phase      = PH_WDATA;
                     state_next.done_count = done_inc;
                     state_next.remaining  = state.remaining - 8'd1;
                     result.out_byte       = req.next_tx_byte;
                     result.action         = ACT_DATA;
                  end
               end
               PH_ADDRR: begin
                  if (status == ST_ADDRR_ACK) begin
                     state_next.phase = PH_RDATA;
                     result.action    = (state.remaining > 8'd1) ? ACT_RACK : ACT_RNACK;
                  end
               end
               PH_RDATA: begin
                  if (status == ST_RDATA_ACK || status == ST_RDATA_NACK) begin
                     result.store_valid    = 1'b1;
                     result.stored_byte    = req.received_byte;
                     state_next.done_count = done_inc;
                     state_next.remaining  = remaining_dec;
                     if (remaining_dec > 8'd1) begin
                        state_next.phase = PH_RDATA;
                        result.action    = ACT_RACK;
                     end else if (remaining_dec == 8'd1) begin
                        state_next.phase = PH_RDATA;
                        result.action    = ACT_RNACK;
                     end
                  end
               end
               default: begin
                  // Idle or unreachable phase: release and stay idle.
                  state_next.phase = PH_IDLE;
               end
            endcase
         end
      endcase

      result.byte_count = state_next.done_count;
      result.phase      = state_next.phase;
   end

endmodule

/* tb/i2c_master_transfer_sequencer_test.sv */
// Self-checking testbench for the I2C master transfer sequencer.
`timescale 1ns / 1ps

module i2c_master_transfer_sequencer_test;
   import i2cms_pkg::*;

   localparam int QUIET_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int BEATS_PER_RUN = 534;

   // One directed step: a request beat and, where it is obvious, its typed-in response.
   typedef struct {
      req_type    req;
      logic       literal;
      result_type result;
   } script_row_type;

   logic       clock = 1'b0;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_command;
   logic [6:0] req_device_address;
   logic [7:0] req_transfer_length;
   logic [7:0] req_status_code;
   logic [7:0] req_received_byte;
   logic [7:0] req_next_tx_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [2:0] rsp_action;
   logic [7:0] rsp_out_byte;
   logic       rsp_store_valid;
   logic [7:0] rsp_stored_byte;
   logic [7:0] rsp_byte_count;
   logic [2:0] rsp_phase;
   logic       rsp_accepted;

   state_type      bus_state;
   result_type     awaited_actions[$];
   script_row_type script[$];
   int             failures = 0;
   int             quiet_cycles = 0;
   int             sender_idle_pct = 0;
   int             receiver_idle_pct = 0;
   bit             hold_request = 1'b0;

   i2c_master_transfer_sequencer uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_device_address  (req_device_address),
      .req_transfer_length (req_transfer_length),
      .req_status_code     (req_status_code),
      .req_received_byte   (req_received_byte),
      .req_next_tx_byte    (req_next_tx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_action          (rsp_action),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_store_valid     (rsp_store_valid),
      .rsp_stored_byte     (rsp_stored_byte),
      .rsp_byte_count      (rsp_byte_count),
      .rsp_phase           (rsp_phase),
      .rsp_accepted        (rsp_accepted)
   );

   // Free-running clock with a 10 ns period.
   always #5 clock = ~clock;

   // Computes the response to one request beat and advances the transfer state.
   function automatic result_type next_bus_action(inout state_type s, input req_type r);
      result_type o;
      logic [7:0] st;
      logic       send_data;
      logic       go_idle;
      o = '0;
      st = r.status_code & ST_MASK;
      send_data = 1'b0;
      go_idle = 1'b0;
      o.action = ACT_NONE;
      case (r.command)
         CMD_START_WRITE, CMD_START_READ: begin
            // A start is taken only from idle; otherwise nothing happens.
            if (s.phase == PH_IDLE) begin
               s.address_byte = {r.device_address, r.command[0]};
               s.phase = (r.command == CMD_START_WRITE) ? PH_STAW : PH_STAR;
               s.remaining = r.transfer_length;
               s.done_count = 8'd0;
               o.action = ACT_START;
               o.accepted = 1'b1;
            end
         end
         CMD_STOP: begin
            o.action = ACT_STOP;
         end
         default: begin
            case (s.phase)
               PH_STAW, PH_STAR: begin
                  if (st == ST_START || st == ST_RESTART) begin
                     s.phase = (s.phase == PH_STAW) ? PH_ADDRW : PH_ADDRR;
                     o.out_byte = s.address_byte;
                     o.action = ACT_ADDR;
                  end else begin
                     go_idle = 1'b1;
                  end
               end
               PH_ADDRW: begin
                  if (st == ST_ADDRW_ACK) begin
                     s.phase = PH_WDATA;
                     send_data = 1'b1;
                  end else begin
                     go_idle = 1'b1;
                  end
               end
               PH_WDATA: begin
                  if (st == ST_WDATA_ACK) send_data = 1'b1;
                  else go_idle = 1'b1;
               end
               PH_ADDRR: begin
                  if (st == ST_ADDRR_ACK) begin
                     s.phase = PH_RDATA;
                     o.action = (s.remaining > 8'd1) ? ACT_RACK : ACT_RNACK;
                  end else begin
                     go_idle = 1'b1;
                  end
               end
               PH_RDATA: begin
                  if (st == ST_RDATA_ACK || st == ST_RDATA_NACK) begin
                     // The byte is always stored; the count holds at zero instead of wrapping.
                     o.store_valid = 1'b1;
                     o.stored_byte = r.received_byte;
                     s.done_count = s.done_count + 8'd1;
                     if (s.remaining != 8'd0) s.remaining = s.remaining - 8'd1;
                     if (s.remaining > 8'd1) o.action = ACT_RACK;
                     else if (s.remaining == 8'd1) o.action = ACT_RNACK;
                     else go_idle = 1'b1;
                  end else begin
                     go_idle = 1'b1;
                  end
               end
               default: begin
                  go_idle = 1'b1;
               end
            endcase
         end
      endcase
      // Sending a data byte, or ending the write once the length is used up.
      if (send_data) begin
         if (s.remaining != 8'd0) begin
            o.out_byte = r.next_tx_byte;
            s.done_count = s.done_count + 8'd1;
            s.remaining = s.remaining - 8'd1;
            o.action = ACT_DATA;
         end else begin
            go_idle = 1'b1;
         end
      end
      if (go_idle) begin
         s.phase = PH_IDLE;
         o.action = ACT_RELEASE;
      end
      o.byte_count = s.done_count;
      o.phase = s.phase;
      return o;
   endfunction

   function automatic req_type make_req(cmd_type c, logic [6:0] a, logic [7:0] l,
                                        logic [7:0] st, logic [7:0] rx, logic [7:0] tx);
      req_type r;
      r.command = c;
      r.device_address = a;
      r.transfer_length = l;
      r.status_code = st;
      r.received_byte = rx;
      r.next_tx_byte = tx;
      return r;
   endfunction

   // Directed row checked against the predictor.
   function automatic script_row_type row_p(cmd_type c, logic [6:0] a, logic [7:0] l,
                                            logic [7:0] st, logic [7:0] rx, logic [7:0] tx);
      script_row_type w;
      w.req = make_req(c, a, l, st, rx, tx);
      w.literal = 1'b0;
      w.result = '0;
      return w;
   endfunction

   // Directed row with its response typed in.
   function automatic script_row_type row_l(cmd_type c, logic [6:0] a, logic [7:0] l,
                                            logic [7:0] st, logic [7:0] rx, logic [7:0] tx,
                                            action_type act, logic [7:0] ob, logic sv,
                                            logic [7:0] sb, logic [7:0] cnt,
                                            phase_type ph, logic acc);
      script_row_type w;
      w.req = make_req(c, a, l, st, rx, tx);
      w.literal = 1'b1;
      w.result.action = act;
      w.result.out_byte = ob;
      w.result.store_valid = sv;
      w.result.stored_byte = sb;
      w.result.byte_count = cnt;
      w.result.phase = ph;
      w.result.accepted = acc;
      return w;
   endfunction

   // Start length: mostly short transfers, now and then any length.
   function automatic logic [7:0] pick_length();
      int p;
      p = $urandom_range(99);
      if (p < 80) return 8'($urandom_range(6));
      if (p < 95) return 8'($urandom_range(40, 7));
      return 8'($urandom_range(255));
   endfunction

   // Random beat: mostly the status the current phase hopes for, with some noise.
   function automatic req_type next_random_beat();
      req_type    r;
      int         roll;
      logic [7:0] code;
      r.command = CMD_EVENT;
      r.device_address = 7'($urandom);
      r.transfer_length = pick_length();
      r.status_code = 8'($urandom);
      r.received_byte = 8'($urandom);
      r.next_tx_byte = 8'($urandom);
      roll = $urandom_range(99);
      if (roll < 6) begin
         r.command = cmd_type'($urandom_range(3));
         r.transfer_length = 8'($urandom);
         return r;
      end
      if (roll < 9) begin
         r.command = CMD_STOP;
         return r;
      end
      if (roll < 12) begin
         r.command = $urandom_range(1) ? CMD_START_READ : CMD_START_WRITE;
         return r;
      end
      case (bus_state.phase)
         PH_IDLE: begin
            r.command = $urandom_range(1) ? CMD_START_READ : CMD_START_WRITE;
            return r;
         end
         PH_STAW, PH_STAR: code = $urandom_range(1) ? ST_START : ST_RESTART;
         PH_ADDRW: code = ST_ADDRW_ACK;
         PH_WDATA: code = ($urandom_range(99) < 5) ? ST_WDATA_NACK : ST_WDATA_ACK;
         PH_ADDRR: code = ST_ADDRR_ACK;
         PH_RDATA: begin
            code = (bus_state.remaining > 8'd1) ? ST_RDATA_ACK : ST_RDATA_NACK;
            if ($urandom_range(99) < 20) code = $urandom_range(1) ? ST_RDATA_ACK : ST_RDATA_NACK;
         end
         default: code = 8'($urandom);
      endcase
      r.status_code = (code & ST_MASK) | 8'($urandom_range(7));
      return r;
   endfunction

   // Offers one request beat, waits for it to be taken and records what it should cause.
   task automatic send_beat(input req_type r, input logic literal, input result_type typed);
      result_type predicted;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_command <= r.command;
      req_device_address <= r.device_address;
      req_transfer_length <= r.transfer_length;
      req_status_code <= r.status_code;
      req_received_byte <= r.received_byte;
      req_next_tx_byte <= r.next_tx_byte;
      do @(posedge clock); while (req_stall);
      predicted = next_bus_action(bus_state, r);
      awaited_actions.push_back(literal ? typed : predicted);
   endtask

   task automatic note_failure(input string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
   endtask

   // Compares one response beat with the oldest awaited one.
   task automatic check_beat();
      result_type want;
      result_type got;
      got.action = action_type'(rsp_action);
      got.out_byte = rsp_out_byte;
      got.store_valid = rsp_store_valid;
      got.stored_byte = rsp_stored_byte;
      got.byte_count = rsp_byte_count;
      got.phase = phase_type'(rsp_phase);
      got.accepted = rsp_accepted;
      if (awaited_actions.size() == 0) begin
         note_failure($sformatf("tb: response beat with none awaited: act=%0d ph=%0d",
                                rsp_action, rsp_phase));
      end else begin
         want = awaited_actions.pop_front();
         if (got.action !== want.action || got.out_byte !== want.out_byte ||
             got.store_valid !== want.store_valid || got.stored_byte !== want.stored_byte ||
             got.byte_count !== want.byte_count || got.phase !== want.phase ||
             got.accepted !== want.accepted)
            note_failure($sformatf(
               "tb: mismatch exp act=%0d ob=%02h sv=%0b sb=%02h cnt=%0d ph=%0d acc=%0b %s%0d %s",
               want.action, want.out_byte, want.store_valid, want.stored_byte,
               want.byte_count, want.phase, want.accepted, "got act=", got.action,
               $sformatf("ob=%02h sv=%0b sb=%02h cnt=%0d ph=%0d acc=%0b", got.out_byte,
                         got.store_valid, got.stored_byte, got.byte_count, got.phase,
                         got.accepted)));
      end
   endtask

   // Receiver: checks each response beat and stalls at random or for a long hold-off.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) check_beat();
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < receiver_idle_pct);
         end
      end
   end

   // Watchdog: ends the run when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // Sender: reset, the directed script, three random runs, then the drain.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = CMD_STOP;
      req_device_address = '0;
      req_transfer_length = '0;
      req_status_code = '0;
      req_received_byte = '0;
      req_next_tx_byte = '0;
      bus_state = '0;
      bus_state.phase = PH_IDLE;
      script = '{
         // Event and stop right after reset.
         row_l(CMD_EVENT, 7'h00, 8'h00, 8'h08, 8'h00, 8'h00,
               ACT_RELEASE, 8'h00, 1'b0, 8'h00, 8'd0, PH_IDLE, 1'b0),
         row_l(CMD_STOP, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               ACT_STOP, 8'h00, 1'b0, 8'h00, 8'd0, PH_IDLE, 1'b0),
         // Two-byte write to the top address, with a start while busy.
         row_l(CMD_START_WRITE, 7'h7F, 8'd2, 8'h00, 8'h00, 8'h00,
               ACT_START, 8'h00, 1'b0, 8'h00, 8'd0, PH_STAW, 1'b1),
         row_l(CMD_START_READ, 7'h00, 8'd0, 8'h00, 8'h00, 8'h00,
               ACT_NONE, 8'h00, 1'b0, 8'h00, 8'd0, PH_STAW, 1'b0),
         row_l(CMD_EVENT, 7'h00, 8'h00, 8'h0F, 8'h00, 8'h00,
               ACT_ADDR, 8'hFE, 1'b0, 8'h00, 8'd0, PH_ADDRW, 1'b0),
         row_l(CMD_EVENT, 7'h00, 8'h00, 8'h18, 8'h00, 8'hFF,
               ACT_DATA, 8'hFF, 1'b0, 8'h00, 8'd1, PH_WDATA, 1'b0),
         row_l(CMD_EVENT, 7'h00, 8'h00, 8'h2F, 8'h00, 8'h00,
               ACT_DATA, 8'h00, 1'b0, 8'h00, 8'd2, PH_WDATA, 1'b0),
         row_l(CMD_EVENT, 7'h00, 8'h00, 8'h28, 8'h00, 8'h11,
               ACT_RELEASE, 8'h00, 1'b0, 8'h00, 8'd2, PH_IDLE, 1'b0),
         // Longest write, stopped in the data phase and then ended by a NACK.
         row_p(CMD_START_WRITE, 7'h00, 8'hFF, 8'h00, 8'h00, 8'h00),
         row_p(CMD_EVENT, 7'h00, 8'h00, 8'h10, 8'h00, 8'h00),
         row_p(CMD_EVENT, 7'h00, 8'h00, 8'h18, 8'h00, 8'h5A),
         row_l(CMD_STOP, 7'h00, 8'h00, 8'h00, 8'h00, 8'h00,
               ACT_STOP, 8'h00, 1'b0, 8'h00, 8'd1, PH_WDATA, 1'b0),
         row_l(CMD_EVENT, 7'h00, 8'h00, 8'h30, 8'h00, 8'h00,
               ACT_RELEASE, 8'h00, 1'b0, 8'h00, 8'd1, PH_IDLE, 1'b0),
         // Read of length zero: one byte stored, the count does not wrap.
         row_p(CMD_START_READ, 7'h55, 8'd0, 8'h00, 8'h00, 8'h00),
         row_p(CMD_EVENT, 7'h00, 8'h00, 8'h08, 8'h00, 8'h00),
         row_p(CMD_EVENT, 7'h00, 8'h00, 8'h40, 8'h00, 8'h00),
         row_l(CMD_EVENT, 7'h00, 8'h00, 8'h58, 8'hFF, 8'h00,
               ACT_RELEASE, 8'h00, 1'b1, 8'hFF, 8'd1, PH_IDLE, 1'b0),
         // Three-byte read; the last byte comes with the release.
         row_p(CMD_START_READ, 7'h01, 8'd3, 8'h00, 8'h00, 8'h00),
         row_p(CMD_EVENT, 7'h00, 8'h00, 8'h17, 8'h00, 8'h00),
         row_p(CMD_EVENT, 7'h00, 8'h00, 8'h40, 8'h00, 8'h00),
         row_p(CMD_EVENT, 7'h00, 8'h00, 8'h50, 8'h00, 8'h00),
         row_p(CMD_EVENT, 7'h00, 8'h00, 8'h57, 8'hA5, 8'h00),
         row_l(CMD_EVENT, 7'h00, 8'h00, 8'h58, 8'h5A, 8'h00,
               ACT_RELEASE, 8'h00, 1'b1, 8'h5A, 8'd3, PH_IDLE, 1'b0),
         // Write of length zero ends at the address ACK.
         row_p(CMD_START_WRITE, 7'h2A, 8'd0, 8'h00, 8'h00, 8'h00),
         row_p(CMD_EVENT, 7'h00, 8'h00, 8'h08, 8'h00, 8'h00),
         row_l(CMD_EVENT, 7'h00, 8'h00, 8'h18, 8'h00, 8'h77,
               ACT_RELEASE, 8'h00, 1'b0, 8'h00, 8'd0, PH_IDLE, 1'b0),
         // Unexpected status right after the start.
         row_p(CMD_START_READ, 7'h7F, 8'd1, 8'h00, 8'h00, 8'h00),
         row_l(CMD_EVENT, 7'h00, 8'h00, 8'hFF, 8'h00, 8'h00,
               ACT_RELEASE, 8'h00, 1'b0, 8'h00, 8'd0, PH_IDLE, 1'b0)
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      sender_idle_pct = 38;
      receiver_idle_pct = 68;

      // Directed script.
      foreach (script[i]) send_beat(script[i].req, script[i].literal, script[i].result);

      // Random runs: receiver-heavy idling, sender-heavy idling, then none with a hold-off.
      for (int run = 0; run < 3; run++) begin
         case (run)
            0: begin
               sender_idle_pct = 38;
               receiver_idle_pct = 68;
            end
            1: begin
               sender_idle_pct = 68;
               receiver_idle_pct = 38;
            end
            default: begin
               sender_idle_pct = 0;
               receiver_idle_pct = 0;
               hold_request = 1'b1;
            end
         endcase
         repeat (BEATS_PER_RUN) send_beat(next_random_beat(), 1'b0, '0);
      end
      req_valid <= 1'b0;

      // Drain, then wait for any stray beat.
      while (awaited_actions.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (awaited_actions.size() != 0)
         note_failure("tb: response beats still awaited at the end");
      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
